FILE: sv/wts_pkg.sv
// shared types and constants of the woven texture sampler
package wts_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WARP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEFT       = 3'd4;

    localparam logic [1:0] REGION_BG   = 2'd0;
    localparam logic [1:0] REGION_WARP = 2'd1;
    localparam logic [1:0] REGION_WEFT = 2'd2;

    localparam logic [15:0] SCALE_DEFAULT = 16'd3072;
    localparam logic [15:0] BAND_MIN      = 16'd1311;
    localparam logic [15:0] BAND_MAX      = 16'd64225;
    localparam logic [15:0] BAND_RESET    = 16'd43254;

    localparam logic [23:0] BG_RGB_RESET   = 24'd2367775;
    localparam logic [23:0] WARP_RGB_RESET = 24'd14404792;
    localparam logic [23:0] WEFT_RGB_RESET = 24'd4693677;

    localparam logic [6:0] VIS_TOP = 7'd100;
    localparam logic [6:0] VIS_LOW = 7'd62;

    localparam int DEN_W  = 31;
    localparam int NUM_W  = 40;
    localparam int QBITS  = 8;
    localparam logic [DEN_W-1:0] DEN_SCALE = 31'd20000;

    // cycles from the accepting edge to the edge that takes the result
    localparam int LATENCY = 14;

    typedef struct packed {
        logic [1:0]  region;
        logic        shaded;
        logic [23:0] rgb;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [6:0]  vis;
        logic [16:0] d2;
    } cls_t;

    function automatic logic [15:0] clamp_band(input logic [15:0] b);
        logic [15:0] r;
        r = b;
        if (b < BAND_MIN)
        begin
            r = BAND_MIN;
        end
        else if (b > BAND_MAX)
        begin
            r = BAND_MAX;
        end
        return r;
    endfunction

endpackage

FILE: sv/weave_texture_sampler_core.sv
// woven cloth texture sampler, fully pipelined
//
// One item (a signed u,v coordinate pair) may be started in every clock cycle,
// and each gives exactly one color on red_out/green_out/blue_out/region_code,
// shown for one cycle with done, in start order. The depth is set by the
// eight-step restoring divider that forms the rounded strand shading, one
// quotient bit per stage, after the multiply and classify stages. The result
// side cannot stall, so busy is high only in the first cycle after reset.
// Registers are written through cfg_we/cfg_addr/cfg_wdata; the user must do so
// only while no item is in flight, which the block does not enforce. Indexes above four are ignored.
module weave_texture_sampler_core
    import wts_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [31:0]    u_coord,
    input  logic signed [31:0]    v_coord,
    output logic                  done,
    output logic [7:0]            red_out,
    output logic [7:0]            green_out,
    output logic [7:0]            blue_out,
    output logic [1:0]            region_code,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int PF = COORD_FRAC_BITS + 8;

    logic [15:0]      scale_reg;
    logic [15:0]      w_reg;
    logic [DEN_W-1:0] den_reg;
    logic [23:0]      bg_rgb_reg;
    logic [23:0]      warp_rgb_reg;
    logic [23:0]      weft_rgb_reg;
    logic [15:0]      band_next;

    logic busy_reg;

    logic               valid_a_reg;
    logic signed [31:0] u_reg;
    logic signed [31:0] v_reg;

    logic               valid_b_reg;
    logic [PF:0]        pu_reg;
    logic [PF:0]        pv_reg;
    logic signed [48:0] pu_next;
    logic signed [48:0] pv_next;

    logic        valid_c_reg;
    cls_t        cls_reg;
    cls_t        cls_next;
    logic [15:0] fu;
    logic [15:0] fv;
    logic [16:0] du;
    logic [16:0] dv;
    logic        on_warp;
    logic        on_weft;
    logic        warp_top;

    logic        valid_d_reg;
    side_t       side_d_reg;
    logic [22:0] n_reg;
    logic [14:0] cv_reg [0:2];
    logic [22:0] n_next;

    logic             vdiv_reg [0:QBITS];
    side_t            sdiv_reg [0:QBITS];
    logic [NUM_W-1:0] rem_reg  [0:QBITS][0:2];
    logic [7:0]       q_reg    [0:QBITS][0:2];
    logic [NUM_W-1:0] rem_next [1:QBITS][0:2];
    logic [7:0]       q_next   [1:QBITS][0:2];
    logic [NUM_W-1:0] num_next [0:2];

    logic       done_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [1:0] region_reg;

    // configuration registers
    assign band_next = clamp_band(cfg_wdata[15:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg    <= SCALE_DEFAULT;
            w_reg        <= BAND_RESET;
            den_reg      <= DEN_W'(BAND_RESET) * DEN_SCALE;
            bg_rgb_reg   <= BG_RGB_RESET;
            warp_rgb_reg <= WARP_RGB_RESET;
            weft_rgb_reg <= WEFT_RGB_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SCALE:
                begin
                    scale_reg <= (cfg_wdata[15:0] == 16'd0) ? SCALE_DEFAULT : cfg_wdata[15:0];
                end
                REG_BAND:
                begin
                    w_reg   <= band_next;
                    den_reg <= DEN_W'(band_next) * DEN_SCALE;
                end
                REG_BACKGROUND: bg_rgb_reg   <= cfg_wdata;
                REG_WARP:       warp_rgb_reg <= cfg_wdata;
                REG_WEFT:       weft_rgb_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
            for (int k = 0; k <= QBITS; k++)
            begin
                vdiv_reg[k] <= 1'b0;
            end
            done_reg    <= 1'b0;
        end
        else
        begin
            busy_reg    <= 1'b0;
            valid_a_reg <= start && !busy_reg;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
            vdiv_reg[0] <= valid_d_reg;
            for (int k = 1; k <= QBITS; k++)
            begin
                vdiv_reg[k] <= vdiv_reg[k-1];
            end
            done_reg    <= vdiv_reg[QBITS];
        end
    end

    // products
    assign pu_next = u_reg * $signed({1'b0, scale_reg});
    assign pv_next = v_reg * $signed({1'b0, scale_reg});

    // cell fraction, strand test and top strand
    always_comb
    begin
        fu = pu_reg[PF-1 -: 16];
        fv = pv_reg[PF-1 -: 16];
        du = fu[15] ? {1'b0, fu[14:0], 1'b0} : (17'h10000 - {fu, 1'b0});
        dv = fv[15] ? {1'b0, fv[14:0], 1'b0} : (17'h10000 - {fv, 1'b0});
        on_warp  = du <= {1'b0, w_reg};
        on_weft  = dv <= {1'b0, w_reg};
        warp_top = !(pu_reg[PF] ^ pv_reg[PF]);

        cls_next.side.region = REGION_BG;
        cls_next.side.shaded = 1'b0;
        cls_next.side.rgb    = bg_rgb_reg;
        cls_next.vis         = VIS_TOP;
        cls_next.d2          = 17'd0;
        if (on_warp && (warp_top || !on_weft))
        begin
            cls_next.side.region = REGION_WARP;
            cls_next.side.shaded = 1'b1;
            cls_next.side.rgb    = warp_rgb_reg;
            cls_next.vis         = (warp_top || on_weft) ? VIS_TOP : VIS_LOW;
            cls_next.d2          = du;
        end
        else if (on_weft)
        begin
            cls_next.side.region = REGION_WEFT;
            cls_next.side.shaded = 1'b1;
            cls_next.side.rgb    = weft_rgb_reg;
            cls_next.vis         = (warp_top && !on_warp) ? VIS_LOW : VIS_TOP;
            cls_next.d2          = dv;
        end
    end

    // profile numerator 100w - 22d2, never negative since d2 <= w
    assign n_next = ({7'b0, w_reg} * 23'd100) - ({6'b0, cls_reg.d2} * 23'd22);

    // rounded dividend 2*c*vis*n + den/2
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            num_next[ch] = (({25'b0, cv_reg[ch]} * {17'b0, n_reg}) << 1)
                           + {9'b0, den_reg >> 1};
        end
    end

    // restoring division, one quotient bit per stage
    always_comb
    begin
        logic [NUM_W-1:0] den_sh;
        logic             ge;
        for (int k = 0; k < QBITS; k++)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                den_sh = {{(NUM_W-DEN_W){1'b0}}, den_reg} << (QBITS - 1 - k);
                ge = rem_reg[k][ch] >= den_sh;
                rem_next[k+1][ch] = ge ? (rem_reg[k][ch] - den_sh) : rem_reg[k][ch];
                q_next[k+1][ch]   = {q_reg[k][ch][6:0], ge};
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        u_reg <= u_coord;
        v_reg <= v_coord;

        pu_reg <= pu_next[PF:0];
        pv_reg <= pv_next[PF:0];

        cls_reg <= cls_next;

        side_d_reg <= cls_reg.side;
        n_reg      <= n_next;
        cv_reg[0]  <= {7'b0, cls_reg.side.rgb[23:16]} * {8'b0, cls_reg.vis};
        cv_reg[1]  <= {7'b0, cls_reg.side.rgb[15:8]} * {8'b0, cls_reg.vis};
        cv_reg[2]  <= {7'b0, cls_reg.side.rgb[7:0]} * {8'b0, cls_reg.vis};

        sdiv_reg[0] <= side_d_reg;
        for (int ch = 0; ch < 3; ch++)
        begin
            rem_reg[0][ch] <= num_next[ch];
            q_reg[0][ch]   <= 8'd0;
        end
        for (int k = 1; k <= QBITS; k++)
        begin
            sdiv_reg[k] <= sdiv_reg[k-1];
            for (int ch = 0; ch < 3; ch++)
            begin
                rem_reg[k][ch] <= rem_next[k][ch];
                q_reg[k][ch]   <= q_next[k][ch];
            end
        end

        region_reg <= sdiv_reg[QBITS].region;
        if (sdiv_reg[QBITS].shaded)
        begin
            red_reg   <= q_reg[QBITS][0];
            green_reg <= q_reg[QBITS][1];
            blue_reg  <= q_reg[QBITS][2];
        end
        else
        begin
            red_reg   <= sdiv_reg[QBITS].rgb[23:16];
            green_reg <= sdiv_reg[QBITS].rgb[15:8];
            blue_reg  <= sdiv_reg[QBITS].rgb[7:0];
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign red_out     = red_reg;
    assign green_out   = green_reg;
    assign blue_out    = blue_reg;
    assign region_code = region_reg;

endmodule

FILE: sv/wts_checker.sv
// port-level checks of the woven texture sampler, bound to the top level
module wts_checker
    import wts_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic [1:0]            region_code
);

    // every accepted item gives a result a fixed time later
    a_item_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item gave no result");

    // no result without an accepted item
    a_done_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without an item");

    // once ready after reset the block stays ready
    a_busy_stays_low: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy raised after reset");

    // a region code of three never shows on a result
    a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (region_code == REGION_BG || region_code == REGION_WARP
                  || region_code == REGION_WEFT))
        else $error("bad region code");

endmodule

bind weave_texture_sampler_core wts_checker u_wts_checker (.*);

FILE: sim/weave_texture_sampler_core_test.sv
// self-checking testbench of the woven cloth texture sampler core
module weave_texture_sampler_core_test;
    import wts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS      = 16;
    localparam int FRAC_SHIFT     = FRAC_BITS + 8 - 16;
    localparam int CELL_BIT       = FRAC_BITS + 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 100;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] region;
    } color_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic signed [31:0]    u_coord;
    logic signed [31:0]    v_coord;
    logic                  done;
    logic [7:0]            red_out;
    logic [7:0]            green_out;
    logic [7:0]            blue_out;
    logic [1:0]            region_code;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    logic [15:0] scale_reg;
    logic [15:0] band_reg;
    logic [23:0] background_reg;
    logic [23:0] warp_reg;
    logic [23:0] weft_reg;

    color_t expected_colors[$];
    int     error_count;
    int     idle_pct;
    int     stall_cycles;

    weave_texture_sampler_core #(
        .COORD_FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .u_coord     (u_coord),
        .v_coord     (v_coord),
        .done        (done),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .region_code (region_code),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [7:0] shade_channel(longint ch, longint vis, longint w,
                                                 longint d2);
        longint num;
        longint den;
        num = ch * vis * (100 * w - 22 * d2);
        den = 10000 * w;
        return 8'((2 * num + den) / (2 * den));
    endfunction

    function automatic color_t strand_color(logic [23:0] rgb, longint vis, longint w,
                                            longint d2, logic [1:0] region);
        color_t c;
        c.red    = shade_channel(rgb[23:16], vis, w, d2);
        c.green  = shade_channel(rgb[15:8], vis, w, d2);
        c.blue   = shade_channel(rgb[7:0], vis, w, d2);
        c.region = region;
        return c;
    endfunction

    function automatic color_t predict_color(logic signed [31:0] u, logic signed [31:0] v);
        longint s;
        longint w;
        longint pu;
        longint pv;
        longint fu;
        longint fv;
        longint du;
        longint dv;
        logic   on_warp;
        logic   on_weft;
        logic   warp_top;
        color_t c;
        s = (scale_reg == 0) ? longint'(SCALE_DEFAULT) : longint'(scale_reg);
        w = band_reg;
        if (band_reg < BAND_MIN)
        begin
            w = BAND_MIN;
        end
        else if (band_reg > BAND_MAX)
        begin
            w = BAND_MAX;
        end
        pu = longint'(u) * s;
        pv = longint'(v) * s;
        fu = (pu >>> FRAC_SHIFT) & 64'hFFFF;
        fv = (pv >>> FRAC_SHIFT) & 64'hFFFF;
        du = (2 * fu >= 65536) ? 2 * fu - 65536 : 65536 - 2 * fu;
        dv = (2 * fv >= 65536) ? 2 * fv - 65536 : 65536 - 2 * fv;
        on_warp  = (du <= w);
        on_weft  = (dv <= w);
        warp_top = ~(pu[CELL_BIT] ^ pv[CELL_BIT]);
        if (!on_warp && !on_weft)
        begin
            c.red    = background_reg[23:16];
            c.green  = background_reg[15:8];
            c.blue   = background_reg[7:0];
            c.region = REGION_BG;
        end
        else if (on_warp && on_weft)
        begin
            if (warp_top)
            begin
                c = strand_color(warp_reg, VIS_TOP, w, du, REGION_WARP);
            end
            else
            begin
                c = strand_color(weft_reg, VIS_TOP, w, dv, REGION_WEFT);
            end
        end
        else if (on_warp)
        begin
            c = strand_color(warp_reg, warp_top ? VIS_TOP : VIS_LOW, w, du, REGION_WARP);
        end
        else
        begin
            c = strand_color(weft_reg, warp_top ? VIS_LOW : VIS_TOP, w, dv, REGION_WEFT);
        end
        return c;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic pause(int n);
        repeat (n)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    task automatic send_item(logic [31:0] u, logic [31:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            pause(1);
        end
        @(negedge clk);
        start   = 1'b1;
        u_coord = u;
        v_coord = v;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        expected_colors.push_back(predict_color(u, v));
    endtask

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (expected_colors.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = data;
        case (idx)
            REG_SCALE:      scale_reg      = data[15:0];
            REG_BAND:       band_reg       = data[15:0];
            REG_BACKGROUND: background_reg = data[23:0];
            REG_WARP:       warp_reg       = data[23:0];
            REG_WEFT:       weft_reg       = data[23:0];
            default:        ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(6))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd256;
            3:       return 16'hFFFF;
            4:       return SCALE_DEFAULT;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_band();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return BAND_MIN - 16'd1;
            2:       return BAND_MIN;
            3:       return BAND_MAX;
            4:       return BAND_MAX + 16'd1;
            5:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_rgb();
        case ($urandom_range(4))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(3))
            0:       return 32'($signed(20'($urandom)));
            default: return 32'($urandom);
        endcase
    endfunction

    task automatic test_reset_values();
        send_item(32'h0000_0000, 32'h0000_0000);
        send_item(32'h0000_0AAB, 32'h0000_0AAB);
        send_item(pick_coord(), pick_coord());
    endtask

    task automatic test_regions();
        drain();
        write_reg(REG_SCALE, 24'd256);
        write_reg(REG_BAND, 24'h8000);
        send_item(32'h0000_0000, 32'h0000_0000);
        send_item(32'h0000_8000, 32'h0000_0000);
        send_item(32'h0001_8000, 32'h0000_0000);
        send_item(32'h0000_0000, 32'h0000_8000);
        send_item(32'h0001_0000, 32'h0000_8000);
        send_item(32'h0000_8000, 32'h0000_8000);
        send_item(32'h0001_8000, 32'h0000_8000);
        send_item(32'h0000_4000, 32'h0000_0000);
        send_item(32'h0000_3FFF, 32'h0000_0000);
        send_item(32'h8000_0000, 32'h7FFF_FFFF);
        send_item(32'h7FFF_FFFF, 32'h8000_0000);
        send_item(32'hFFFF_8000, 32'hFFFF_FFFF);
    endtask

    task automatic test_scale_extremes();
        drain();
        write_reg(REG_SCALE, 24'd0);
        send_item(32'h0000_0AAB, 32'h0000_0000);
        drain();
        write_reg(REG_SCALE, 24'hFFFF);
        send_item(32'h7FFF_FFFF, 32'h8000_0000);
        send_item(32'h0000_0080, 32'hFFFF_FF80);
        drain();
        write_reg(REG_SCALE, 24'd1);
        send_item(32'h0080_0000, 32'h0180_0000);
    endtask

    task automatic test_band_clamp();
        drain();
        write_reg(REG_SCALE, 24'd256);
        write_reg(REG_BAND, 24'd0);
        send_item(32'h0000_8000, 32'h0000_8000);
        send_item(32'h0000_8290, 32'h0001_7D70);
        drain();
        write_reg(REG_BAND, 24'hFFFF);
        send_item(32'h0000_0200, 32'h0001_0000);
        send_item(32'h0000_0000, 32'h0000_0000);
    endtask

    task automatic test_colors_and_unused_regs();
        drain();
        write_reg(REG_BAND, 24'h8000);
        write_reg(REG_BACKGROUND, 24'hFFFFFF);
        write_reg(REG_WARP, 24'h000000);
        write_reg(REG_WEFT, 24'hFFFFFF);
        for (int a = REG_WEFT + 1; a < 2 ** CFG_IDX_W; a++)
        begin
            write_reg(a[CFG_IDX_W-1:0], 24'($urandom));
        end
        send_item(32'h0000_0000, 32'h0000_0000);
        send_item(32'h0000_8000, 32'h0000_4000);
        send_item(32'h0001_0000, 32'h0000_8000);
    endtask

    task automatic test_random_phases();
        int phase_idle[6] = '{0, 61, 10, 0, 61, 10};
        foreach (phase_idle[p])
        begin
            drain();
            idle_pct = 0;
            write_reg(REG_SCALE, 24'(pick_scale()));
            write_reg(REG_BAND, 24'(pick_band()));
            write_reg(REG_BACKGROUND, pick_rgb());
            write_reg(REG_WARP, pick_rgb());
            write_reg(REG_WEFT, pick_rgb());
            idle_pct = phase_idle[p];
            repeat (ITEMS_PER_PHASE)
            begin
                send_item(pick_coord(), pick_coord());
            end
        end
    endtask

    always @(posedge clk)
    begin
        color_t want;
        if (rst_n && done)
        begin
            if (expected_colors.size() == 0)
            begin
                report_mismatch("result with no item outstanding");
            end
            else
            begin
                want = expected_colors.pop_front();
                if (red_out !== want.red)
                begin
                    report_mismatch($sformatf("red_out %0d, want %0d", red_out, want.red));
                end
                if (green_out !== want.green)
                begin
                    report_mismatch($sformatf("green_out %0d, want %0d", green_out,
                                              want.green));
                end
                if (blue_out !== want.blue)
                begin
                    report_mismatch($sformatf("blue_out %0d, want %0d", blue_out, want.blue));
                end
                if (region_code !== want.region)
                begin
                    report_mismatch($sformatf("region_code %0d, want %0d", region_code,
                                              want.region));
                end
            end
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
        end
        $display("weave_texture_sampler_core_test NOT OK");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        u_coord        = '0;
        v_coord        = '0;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        error_count    = 0;
        idle_pct       = 0;
        scale_reg      = SCALE_DEFAULT;
        band_reg       = BAND_RESET;
        background_reg = BG_RGB_RESET;
        warp_reg       = WARP_RGB_RESET;
        weft_reg       = WEFT_RGB_RESET;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_regions();
        test_scale_extremes();
        test_band_clamp();
        test_colors_and_unused_regs();
        test_random_phases();

        drain();
        repeat (LATENCY + 4) @(posedge clk);
        if (expected_colors.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", expected_colors.size()));
        end
        if (error_count == 0)
        begin
            $display("weave_texture_sampler_core_test OK");
        end
        else
        begin
            $display("weave_texture_sampler_core_test NOT OK");
        end
        $finish;
    end

endmodule
